// File: src/rcnh_pkg.sv
`default_nettype none
package rcnh_pkg;

    // Coordinate and angle formats.
    localparam int COORD_FRAC_BITS = 16;
    localparam int ANGLE_BITS      = 16;

    // Direction vector fraction bits and CORDIC depth.
    localparam int DIR_FRAC     = 28;
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008218;

    // Miss sentinel, 10000.0 in coordinate format, saturated to 32 bits.
    localparam longint MISS_RAW = longint'(10000) << COORD_FRAC_BITS;
    localparam logic signed [31:0] MISS_COORD =
        (MISS_RAW > 64'sd2147483647) ? 32'sh7fffffff : MISS_RAW[31:0];

    localparam logic [30:0] RADIUS_RESET = 31'd6554;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam logic signed [32:0] ATAN_TABLE [0:CORDIC_STEPS-1] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331, 33'sd21354465, 33'sd10679838, 33'sd5340245,
        33'sd2670163, 33'sd1335087, 33'sd667544, 33'sd333772, 33'sd166886,
        33'sd83443, 33'sd41722, 33'sd20861, 33'sd10430, 33'sd5215, 33'sd2608,
        33'sd1304, 33'sd652, 33'sd326, 33'sd163, 33'sd81, 33'sd41, 33'sd20,
        33'sd10, 33'sd5, 33'sd3, 33'sd1
    };

    // Payload carried through the CORDIC stages.
    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [32:0] ux;
        logic signed [32:0] uy;
        logic [1:0]         quad;
    } ray_t;

    // Payload carried through the square root stages.
    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [37:0] proj;
        logic               miss;
    } tail_t;

endpackage
`default_nettype wire

// File: src/ray_circle_nearest_hit_top.sv
// Channel  | Signals                      | Contents (lowest bits first)
// input    | s_tvalid s_tready s_tdata    | sensor_x, sensor_y, obstacle_x, obstacle_y, ray_angle
// output   | m_tvalid m_tready m_tdata    | point_x, point_y; m_tuser holds hit
// config   | cfg_we cfg_wdata             | obstacle_radius
//
// One ray enters per cycle while the output is not stalled; a ray passes the input register,
// the 30 CORDIC stages and the 31 square root stages, one iteration per stage, among the rest.
// Reset clears all stage valid bits and loads the radius with its default.
// The whole pipeline advances when the output register is empty or being taken, so a
// stall holds every stage in place and nothing is lost or repeated.
`default_nettype none
module ray_circle_nearest_hit_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // sensor_x, sensor_y, obstacle_x, obstacle_y, ray_angle
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // point_x, point_y
    output logic [63:0]       m_tdata,
    // hit
    output logic [0:0]        m_tuser,
    input  wire logic         cfg_we,
    input  wire logic [30:0]  cfg_wdata
);

    localparam int NC = rcnh_pkg::CORDIC_STEPS;
    localparam int NS = rcnh_pkg::SQRT_STEPS;

    logic adv;
    logic [30:0] radius_reg;

    // Pipeline moves when the output register can take a new result.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= rcnh_pkg::RADIUS_RESET;
        else if (cfg_we)
            radius_reg <= cfg_wdata;
    end

    // ---------------- Input stage: angle reduction and difference vector ----------
    logic signed [31:0] in_sx, in_sy, in_ox, in_oy;
    logic [31:0]        a32, a_res;
    logic [1:0]         a_quad;
    rcnh_pkg::ray_t     in_ray;

    assign in_sx  = s_tdata[31:0];
    assign in_sy  = s_tdata[63:32];
    assign in_ox  = s_tdata[95:64];
    assign in_oy  = s_tdata[127:96];
    assign a32    = {s_tdata[128 +: rcnh_pkg::ANGLE_BITS], {(32-rcnh_pkg::ANGLE_BITS){1'b0}}};
    assign a_quad = 2'((a32 + 32'h2000_0000) >> 30);
    assign a_res  = a32 - {a_quad, 30'd0};

    always_comb
    begin
        in_ray.sx   = in_sx;
        in_ray.sy   = in_sy;
        in_ray.quad = a_quad;
        in_ray.ux   = {in_ox[31], in_ox} - {in_sx[31], in_sx};
        in_ray.uy   = {in_oy[31], in_oy} - {in_sy[31], in_sy};
    end

    logic                 cv_reg [0:NC];
    logic signed [31:0]   cx_reg [0:NC];
    logic signed [31:0]   cy_reg [0:NC];
    logic signed [32:0]   cz_reg [0:NC];
    rcnh_pkg::ray_t       cr_reg [0:NC];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else if (adv)
            cv_reg[0] <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg[0] <= rcnh_pkg::CORDIC_GAIN;
            cy_reg[0] <= '0;
            cz_reg[0] <= {a_res[31], a_res};
            cr_reg[0] <= in_ray;
        end
    end

    // ---------------- CORDIC rotation, one iteration per stage --------------------
    for (genvar i = 0; i < NC; i++)
    begin : g_cordic
        logic signed [31:0] xs, ys;
        assign xs = cx_reg[i] >>> i;
        assign ys = cy_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[i+1] <= 1'b0;
            else if (adv)
                cv_reg[i+1] <= cv_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!cz_reg[i][32])
                begin
                    cx_reg[i+1] <= cx_reg[i] - ys;
                    cy_reg[i+1] <= cy_reg[i] + xs;
                    cz_reg[i+1] <= cz_reg[i] - rcnh_pkg::ATAN_TABLE[i];
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + ys;
                    cy_reg[i+1] <= cy_reg[i] - xs;
                    cz_reg[i+1] <= cz_reg[i] + rcnh_pkg::ATAN_TABLE[i];
                end
                cr_reg[i+1] <= cr_reg[i];
            end
        end
    end

    // ---------------- Quadrant fix-up and dot/cross products ----------------------
    logic signed [31:0] dir_s, dir_c;
    rcnh_pkg::ray_t     cr_last;
    assign cr_last = cr_reg[NC];

    always_comb
    begin
        case (cr_last.quad)
            2'd0:
            begin
                dir_c = cx_reg[NC];
                dir_s = cy_reg[NC];
            end
            2'd1:
            begin
                dir_c = -cy_reg[NC];
                dir_s = cx_reg[NC];
            end
            2'd2:
            begin
                dir_c = -cx_reg[NC];
                dir_s = -cy_reg[NC];
            end
            default:
            begin
                dir_c = cy_reg[NC];
                dir_s = -cx_reg[NC];
            end
        endcase
    end

    logic               pv_reg;
    logic signed [64:0] pxs_reg, pyc_reg, pxc_reg, pys_reg;
    logic signed [31:0] pdx_reg, pdy_reg, psx_reg, psy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (adv)
            pv_reg <= cv_reg[NC];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pxs_reg <= cr_last.ux * dir_s;
            pyc_reg <= cr_last.uy * dir_c;
            pxc_reg <= cr_last.ux * dir_c;
            pys_reg <= cr_last.uy * dir_s;
            pdx_reg <= dir_s;
            pdy_reg <= dir_c;
            psx_reg <= cr_last.sx;
            psy_reg <= cr_last.sy;
        end
    end

    // ---------------- Projection, distance and miss test --------------------------
    logic signed [65:0] dot_sum, cross_sum;
    logic [65:0]        cross_abs;
    logic [37:0]        d_full;
    rcnh_pkg::tail_t    d_tail;

    assign dot_sum   = {pxs_reg[64], pxs_reg} + {pyc_reg[64], pyc_reg};
    assign cross_sum = {pxc_reg[64], pxc_reg} - {pys_reg[64], pys_reg};
    assign cross_abs = cross_sum[65] ? 66'(-cross_sum) : 66'(cross_sum);
    assign d_full    = cross_abs[65:28];

    always_comb
    begin
        d_tail.sx   = psx_reg;
        d_tail.sy   = psy_reg;
        d_tail.dx   = pdx_reg;
        d_tail.dy   = pdy_reg;
        d_tail.proj = dot_sum[65:28];
        d_tail.miss = dot_sum[65] || (d_full > {7'd0, radius_reg});
    end

    logic            dv_reg;
    logic [30:0]     d_reg;
    rcnh_pkg::tail_t dt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg <= 1'b0;
        else if (adv)
            dv_reg <= pv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg  <= d_full[30:0];
            dt_reg <= d_tail;
        end
    end

    // ---------------- Squares of radius and distance ------------------------------
    logic            qv_reg;
    logic [61:0]     rr_reg, dd_reg;
    rcnh_pkg::tail_t qt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qv_reg <= 1'b0;
        else if (adv)
            qv_reg <= dv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rr_reg <= 62'(radius_reg) * 62'(radius_reg);
            dd_reg <= 62'(d_reg) * 62'(d_reg);
            qt_reg <= dt_reg;
        end
    end

    // ---------------- Integer square root, one result bit per stage ---------------
    logic            sv_reg   [0:NS];
    logic [61:0]     srem_reg [0:NS];
    logic [61:0]     sres_reg [0:NS];
    rcnh_pkg::tail_t st_reg   [0:NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg[0] <= 1'b0;
        else if (adv)
            sv_reg[0] <= qv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            srem_reg[0] <= rr_reg - dd_reg;
            sres_reg[0] <= '0;
            st_reg[0]   <= qt_reg;
        end
    end

    for (genvar j = 0; j < NS; j++)
    begin : g_sqrt
        localparam logic [61:0] BIT = 62'(1) << (60 - 2*j);
        logic [61:0] trial;
        assign trial = sres_reg[j] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[j+1] <= 1'b0;
            else if (adv)
                sv_reg[j+1] <= sv_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (srem_reg[j] >= trial)
                begin
                    srem_reg[j+1] <= srem_reg[j] - trial;
                    sres_reg[j+1] <= (sres_reg[j] >> 1) + BIT;
                end
                else
                begin
                    srem_reg[j+1] <= srem_reg[j];
                    sres_reg[j+1] <= sres_reg[j] >> 1;
                end
                st_reg[j+1] <= st_reg[j];
            end
        end
    end

    // ---------------- Distance along the ray to the nearer crossing ---------------
    rcnh_pkg::tail_t    s_last;
    logic signed [38:0] m_ext, proj_ext;
    assign s_last   = st_reg[NS];
    assign m_ext    = {8'd0, sres_reg[NS][30:0]};
    assign proj_ext = {s_last.proj[37], s_last.proj};

    logic               tv_reg;
    logic signed [38:0] t_reg;
    rcnh_pkg::tail_t    tt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tv_reg <= 1'b0;
        else if (adv)
            tv_reg <= sv_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg  <= (s_last.proj == '0) ? m_ext : proj_ext - m_ext;
            tt_reg <= s_last;
        end
    end

    // ---------------- Offset products, split into high and low partial parts -------
    logic signed [21:0] t_hi;
    logic signed [17:0] t_lo;
    assign t_hi = t_reg[38:17];
    assign t_lo = {1'b0, t_reg[16:0]};

    logic               mv_reg;
    logic signed [53:0] hx_reg, hy_reg;
    logic signed [49:0] lx_reg, ly_reg;
    rcnh_pkg::tail_t    mt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= 1'b0;
        else if (adv)
            mv_reg <= tv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hx_reg <= t_hi * tt_reg.dx;
            hy_reg <= t_hi * tt_reg.dy;
            lx_reg <= t_lo * tt_reg.dx;
            ly_reg <= t_lo * tt_reg.dy;
            mt_reg <= tt_reg;
        end
    end

    // ---------------- Final point, saturation and miss sentinel --------------------
    logic signed [70:0] off_x, off_y;
    logic signed [43:0] pos_x, pos_y;
    logic signed [31:0] sat_x, sat_y;

    // The offset may be negative when the sensor sits inside the circle.
    assign off_x = ({{17{hx_reg[53]}}, hx_reg} <<< 17) + {{21{lx_reg[49]}}, lx_reg};
    assign off_y = ({{17{hy_reg[53]}}, hy_reg} <<< 17) + {{21{ly_reg[49]}}, ly_reg};
    assign pos_x = {{12{mt_reg.sx[31]}}, mt_reg.sx} + {off_x[70], off_x[70:28]};
    assign pos_y = {{12{mt_reg.sy[31]}}, mt_reg.sy} + {off_y[70], off_y[70:28]};

    always_comb
    begin
        if (pos_x > 44'sd2147483647)
            sat_x = 32'sh7fffffff;
        else if (pos_x < -44'sd2147483648)
            sat_x = 32'sh80000000;
        else
            sat_x = pos_x[31:0];
        if (pos_y > 44'sd2147483647)
            sat_y = 32'sh7fffffff;
        else if (pos_y < -44'sd2147483648)
            sat_y = 32'sh80000000;
        else
            sat_y = pos_y[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (adv)
            m_tvalid <= mv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (mt_reg.miss)
            begin
                m_tdata <= {rcnh_pkg::MISS_COORD, rcnh_pkg::MISS_COORD};
                m_tuser <= 1'b0;
            end
            else
            begin
                m_tdata <= {sat_y, sat_x};
                m_tuser <= 1'b1;
            end
        end
    end

    // ---------------- Assertions ---------------------------------------------------
    a_miss_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |->
        (m_tdata == {rcnh_pkg::MISS_COORD, rcnh_pkg::MISS_COORD}))
        else $error("miss result without sentinel point");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    a_stall_freezes_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(mv_reg) && $stable(tv_reg))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire
